>>> design/dscw_pkg.sv
// dscw_pkg: shared types, constants and zone-table functions for the
// disk image sector chain walker. No dependencies.
`default_nettype none

package dscw_pkg;

	// input item kinds (carried on s_tuser)
	localparam logic KIND_WRITE   = 1'b0;
	localparam logic KIND_MEASURE = 1'b1;

	// configuration register indexes
	localparam logic REG_TRACK_COUNT = 1'b0;
	localparam logic REG_DATA_SIZE   = 1'b1;

	// register reset values
	localparam logic [5:0]  TRACK_COUNT_RST = 6'd35;
	localparam logic [18:0] DATA_SIZE_RST   = 19'd174848;

	// sector geometry
	localparam logic [7:0]  SECTOR_DATA  = 8'd254;
	localparam logic [7:0]  LAST_TRACK   = 8'd42;
	localparam logic [18:0] SECTOR_BYTES = 19'd256;

	// result of mapping a track and sector to an image offset
	typedef struct packed {
		logic        ok;
		logic [17:0] offset;
	} loc_t;

	// walk sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOCATE,
		ST_READ_T,
		ST_READ_S,
		ST_FINISH,
		ST_LOAD_LO,
		ST_LOAD_HI,
		ST_RESULT
	} state_t;

	// sectors per track by zone, zero for tracks that do not exist
	function automatic logic [4:0] zone_sectors(input logic [7:0] t);
		logic [4:0] n;
		if (t == 8'd0)       n = 5'd0;
		else if (t <= 8'd17) n = 5'd21;
		else if (t <= 8'd24) n = 5'd19;
		else if (t <= 8'd30) n = 5'd18;
		else if (t <= LAST_TRACK) n = 5'd17;
		else                 n = 5'd0;
		return n;
	endfunction

	// sectors on all tracks below track t, valid for 1 to 42
	function automatic logic [9:0] sectors_before(input logic [5:0] t);
		logic [9:0] tw;
		logic [9:0] n;
		tw = {4'b0000, t};
		if (t <= 6'd17)      n = 10'((tw - 10'd1) * 10'd21);
		else if (t <= 6'd24) n = 10'(10'd357 + (tw - 10'd18) * 10'd19);
		else if (t <= 6'd30) n = 10'(10'd490 + (tw - 10'd25) * 10'd18);
		else                 n = 10'(10'd598 + (tw - 10'd31) * 10'd17);
		return n;
	endfunction

endpackage

`default_nettype wire

>>> design/dscw_locate.sv
// dscw_locate: maps a track and sector to a byte offset in the image and
// checks it against track count, zone, data size and image size. Uses dscw_pkg.
`default_nettype none

module dscw_locate #(
	parameter int IMAGE_BYTES = 262144
) (
	input  wire logic [7:0]  track,
	input  wire logic [7:0]  sector,
	input  wire logic [5:0]  track_count,
	input  wire logic [18:0] data_size,
	output dscw_pkg::loc_t   loc
);
	import dscw_pkg::*;

	logic [4:0]  spt;
	logic [9:0]  index;
	logic [17:0] offset;
	logic [18:0] sector_end;
	logic        track_ok;
	logic        sector_ok;

	// zone lookup and track range
	always_comb begin
		spt       = zone_sectors(track);
		track_ok  = (track != 8'd0) && (track <= {2'b00, track_count});
		sector_ok = (sector < {3'b000, spt});
	end

	// sector index to byte offset, sector end against both size limits
	always_comb begin
		index      = 10'(sectors_before(track[5:0]) + {5'b00000, sector[4:0]});
		offset     = {index, 8'h00};
		sector_end = {1'b0, offset} + SECTOR_BYTES;
		loc.offset = offset;
		loc.ok     = track_ok && sector_ok && (sector_end <= data_size)
			&& (32'(sector_end) <= IMAGE_BYTES);
	end

endmodule

`default_nettype wire

>>> design/disk_image_sector_chain_walker_top.sv
// disk_image_sector_chain_walker_top: image memory, register port and the walk
// sequencer with its shared adder. Uses dscw_pkg and dscw_locate.
//
// Usage:
// - s_* channel takes items. s_tuser selects the kind: a write item stores one
//   image byte and gives no result; a measure item walks the sector chain from
//   the named start sector and gives one result on the m_* channel.
// - The cfg port sets the track count and the data size; write it while idle.
// - A write item leaves the sequencer idle. A measure item holds the input while
//   its chain is walked: after the accept, each sector takes a locate step and
//   two reads on the image memory read port; a finish step forms the end address
//   and, for a valid range, two load steps read the load address; the result is
//   loaded last. A walk stopped by an unreadable sector or the step limit ends in
//   a failed locate step. s_tready is low while a walk runs; m_tvalid rises once the result is loaded.
// - The result sits in an output register; the next item is taken while it
//   waits. A measure item whose result finds that register still full waits in
//   its last state until m_tready frees it.
// - Reset clears the sequencer and sets track count 35 and data size 174848.
//   Image contents are not cleared; sectors must be written before a walk.
`default_nettype none

module disk_image_sector_chain_walker_top #(
	parameter int IMAGE_BYTES = 262144,
	parameter int STEP_LIMIT  = 20000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [18:0] cfg_wdata,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [17:0] byte_address, [25:18] byte_value, [33:26] first_track,
	// [41:34] first_sector, [47:42] zero
	input  wire logic [47:0] s_tdata,
	// [0] kind
	input  wire logic        s_tuser,
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [22:0] file_bytes, [38:23] load_address, [61:39] end_address,
	// [62] range_valid, [63] zero
	output logic [63:0]      m_tdata
);
	import dscw_pkg::*;

	localparam int AW = $clog2(IMAGE_BYTES);

	// input fields
	logic [17:0] in_addr;
	logic [7:0]  in_value;
	logic [7:0]  in_track;
	logic [7:0]  in_sector;
	assign in_addr   = s_tdata[17:0];
	assign in_value  = s_tdata[25:18];
	assign in_track  = s_tdata[33:26];
	assign in_sector = s_tdata[41:34];

	// registers
	state_t      state_q, state_d;
	logic [5:0]  track_count_q;
	logic [18:0] data_size_q;
	logic [7:0]  track_q, track_d;
	logic [7:0]  sector_q, sector_d;
	logic [22:0] total_q, total_d;
	logic [14:0] step_q, step_d;
	logic [17:0] off_q, off_d;
	logic [17:0] first_off_q, first_off_d;
	logic        first_ok_q, first_ok_d;
	logic [7:0]  nt_q, nt_d;
	logic [7:0]  lo_q, lo_d;
	logic [15:0] load_q, load_d;
	logic [22:0] end_q, end_d;
	logic        valid_q, valid_d;
	logic [63:0] out_q;
	logic        out_valid_q;
	logic [7:0]  rd_data_q;
	logic [7:0]  image_mem_q [IMAGE_BYTES];

	// control
	logic        accept;
	logic        mem_we;
	logic [17:0] rd_addr;
	logic        out_load;
	logic [23:0] add_a, add_b, sum;
	loc_t        loc;

	dscw_locate #(
		.IMAGE_BYTES(IMAGE_BYTES)
	) u_locate (
		.track      (track_q),
		.sector     (sector_q),
		.track_count(track_count_q),
		.data_size  (data_size_q),
		.loc        (loc)
	);

	// shared adder
	assign sum = add_a + add_b;

	assign accept = s_tvalid && s_tready;
	assign mem_we = accept && (s_tuser == KIND_WRITE) && (32'(in_addr) < IMAGE_BYTES);

	// sequencer next state and datapath control
	always_comb begin
		state_d     = state_q;
		track_d     = track_q;
		sector_d    = sector_q;
		total_d     = total_q;
		step_d      = step_q;
		off_d       = off_q;
		first_off_d = first_off_q;
		first_ok_d  = first_ok_q;
		nt_d        = nt_q;
		lo_d        = lo_q;
		load_d      = load_q;
		end_d       = end_q;
		valid_d     = valid_q;
		rd_addr     = off_q;
		add_a       = {1'b0, total_q};
		add_b       = 24'd0;
		s_tready    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == KIND_MEASURE)) begin
					track_d    = in_track;
					sector_d   = in_sector;
					total_d    = 23'd0;
					step_d     = 15'd0;
					first_ok_d = 1'b0;
					state_d    = (in_track == 8'd0) ? ST_FINISH : ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				if ((step_q < 15'(STEP_LIMIT)) && loc.ok) begin
					rd_addr = loc.offset;
					off_d   = loc.offset;
					step_d  = step_q + 15'd1;
					if (step_q == 15'd0) begin
						first_ok_d  = 1'b1;
						first_off_d = loc.offset;
					end
					state_d = ST_READ_T;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_READ_T: begin
				// link track is here, fetch link sector
				nt_d    = rd_data_q;
				rd_addr = {off_q[17:8], 8'd1};
				state_d = ST_READ_S;
			end
			ST_READ_S: begin
				if (nt_q == 8'd0) begin
					// end link: its sector byte counts if it fits
					if (rd_data_q <= SECTOR_DATA) begin
						add_b   = {16'd0, rd_data_q};
						total_d = sum[22:0];
					end
					state_d = ST_FINISH;
				end else begin
					add_b    = {16'd0, SECTOR_DATA};
					total_d  = sum[22:0];
					track_d  = nt_q;
					sector_d = rd_data_q;
					state_d  = ST_LOCATE;
				end
			end
			ST_FINISH: begin
				if (first_ok_q && (total_q >= 23'd2)) begin
					// total minus three, end address base
					valid_d = 1'b1;
					rd_addr = {first_off_q[17:8], 8'd2};
					add_b   = 24'hFFFFFD;
					end_d   = (total_q == 23'd2) ? 23'd0 : sum[22:0];
					state_d = ST_LOAD_LO;
				end else begin
					valid_d = 1'b0;
					load_d  = 16'd0;
					end_d   = 23'd0;
					state_d = ST_RESULT;
				end
			end
			ST_LOAD_LO: begin
				lo_d    = rd_data_q;
				rd_addr = {first_off_q[17:8], 8'd3};
				state_d = ST_LOAD_HI;
			end
			ST_LOAD_HI: begin
				load_d  = {rd_data_q, lo_q};
				add_a   = {8'd0, rd_data_q, lo_q};
				add_b   = {1'b0, end_q};
				end_d   = sum[23] ? 23'h7FFFFF : sum[22:0];
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			track_count_q <= TRACK_COUNT_RST;
			data_size_q   <= DATA_SIZE_RST;
			track_q       <= 8'd0;
			sector_q      <= 8'd0;
			total_q       <= 23'd0;
			step_q        <= 15'd0;
			first_ok_q    <= 1'b0;
			valid_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			track_q    <= track_d;
			sector_q   <= sector_d;
			total_q    <= total_d;
			step_q     <= step_d;
			first_ok_q <= first_ok_d;
			valid_q    <= valid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TRACK_COUNT: track_count_q <= cfg_wdata[5:0];
					REG_DATA_SIZE:   data_size_q   <= cfg_wdata;
					default:         ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		off_q       <= off_d;
		first_off_q <= first_off_d;
		nt_q        <= nt_d;
		lo_q        <= lo_d;
		load_q      <= load_d;
		end_q       <= end_d;
		if (out_load) begin
			out_q <= {1'b0, valid_q, end_q, load_q, total_q};
		end
	end

	// image memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			image_mem_q[AW'(in_addr)] <= in_value;
		end
		rd_data_q <= image_mem_q[AW'(rd_addr)];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// the walk never runs past the step limit
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q <= 15'(STEP_LIMIT)))
		else $error("step count beyond limit");

	// a valid range needs at least two file bytes
	a_range_min: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[62]) |-> (m_tdata[22:0] >= 23'd2))
		else $error("valid range with too few bytes");

	// an invalid range reports zero addresses
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[62]) |-> ((m_tdata[38:23] == 16'd0) && (m_tdata[61:39] == 23'd0)))
		else $error("invalid range with nonzero address");

	// a measure item starts a walk and drops ready
	a_measure_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == KIND_MEASURE)) |=> !s_tready)
		else $error("ready held during walk");

endmodule

`default_nettype wire
